// ----- rtl/mic_pkg.sv -----
// shared types and constants for the multiset intersection counter
// no dependencies; imported by multiset_intersection_counter_core
package mic_pkg;

  localparam int VALUE_W = 32;
  localparam int REQ_W   = 2;
  localparam int ST_W    = 2;

  // request kinds carried on the input tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_PROBE  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  // result status carried on the output tuser
  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // one request as it travels down the pipeline
  typedef struct packed {
    req_e               req;
    logic [VALUE_W-1:0] value;
  } item_t;

endpackage

// ----- rtl/multiset_intersection_counter_core.sv -----
// multiset intersection counter: hashed, bucketed count table with insert, probe and clear
// depends on mic_pkg (request and status codes, pipeline item type)

// Accepts one insert, probe or clear transaction per clock cycle while the output is
// not stalled and returns exactly one result transaction for each, in order, through
// stages a to d and the output register. The bucket of a value is its absolute value
// modulo BUCKETS, found by a reciprocal multiply, a constant multiply and a single
// correcting subtract over three pipeline stages; the bucket row (WAYS values with their
// counts) then comes from a row memory with one read and one write port and a registered
// read, and a write forwarding register covers an update to the same row by the
// transaction just ahead. Slot valid bits live in flops, so a clear empties all slots
// together and no clearing pass is needed after reset.
// Throughput is one transaction per cycle; any stall on the output stalls the whole
// pipeline and the input tready with it.
module multiset_intersection_counter_core
  import mic_pkg::*;
#(
  parameter int BUCKETS    = 16,
  parameter int WAYS       = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input requests
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // [31:0] value
  input  logic [7:0]         s_axis_tuser,   // [1:0] req_type, [7:2] zero
  // results
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [31:0] out_value
  output logic [7:0]         m_axis_tuser    // [0] hit, [2:1] status, [7:3] zero
);

  localparam int SLOTS   = BUCKETS * WAYS;
  localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = VALUE_W + COUNT_BITS;
  localparam int ROW_W   = WAYS * ENTRY_W;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BUCKETS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [WAYS-1:0][ENTRY_W-1:0] row_t;

  // pipeline control
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic s_fire;
  assign s_fire = s_axis_tvalid && en;

  // stage a: accepted request and its magnitude
  logic               a_valid_q;
  item_t              a_q;
  logic [VALUE_W-1:0] a_mag_q;
  logic [VALUE_W-1:0] in_mag;

  assign in_mag = s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;

  // stage b: reciprocal product
  logic               b_valid_q;
  item_t              b_q;
  logic [VALUE_W-1:0] b_mag_q;
  logic [63:0]        prod_d, prod_q;

  assign prod_d = 64'(a_mag_q) * 64'(RECIP);

  // stage c: raw remainder, below twice the bucket count
  logic               c_valid_q;
  item_t              c_q;
  logic [BKT_W:0]     rem_d, rem_q;
  logic [63:0]        qb;
  logic [63:0]        rem_full;

  assign qb       = 64'(prod_q[63:32]) * 64'(BUCKETS);
  assign rem_full = 64'(b_mag_q) - qb;
  assign rem_d    = rem_full[BKT_W:0];

  // bucket after the one correcting subtract
  logic [BKT_W:0]     rem_fix;
  logic [BKT_W-1:0]   bucket_c;

  assign rem_fix  = (rem_q >= (BKT_W+1)'(BUCKETS)) ? (rem_q - (BKT_W+1)'(BUCKETS)) : rem_q;
  assign bucket_c = rem_fix[BKT_W-1:0];

  // stage d: row lookup and update
  logic               d_valid_q;
  item_t              d_q;
  logic [BKT_W-1:0]   d_bucket_q;
  row_t               rd_q;

  // write forwarding for the row written by the transaction just ahead
  logic               wr_en_q;
  logic [BKT_W-1:0]   wr_bucket_q;
  row_t               wr_row_q;

  logic [SLOTS-1:0]   slot_valid_q;
  row_t               slot_mem [BUCKETS];

  row_t               row_cur, row_new;
  logic [WAYS-1:0]    way_vld, way_match;
  logic [SLOT_W-1:0]  slot_idx [WAYS];
  logic               found, has_free;
  logic [WAY_W-1:0]   match_way, free_way;
  logic [COUNT_BITS-1:0] match_cnt;
  logic               wr_en_d;
  logic               set_valid;
  logic [SLOT_W-1:0]  set_idx;
  logic               clear_all;
  logic               hit_d;
  logic [VALUE_W-1:0] out_value_d;
  status_e            status_d;

  // ways of the addressed bucket, compared in parallel
  always_comb begin
    row_cur = (wr_en_q && (wr_bucket_q == d_bucket_q)) ? wr_row_q : rd_q;
    found     = 1'b0;
    has_free  = 1'b0;
    match_way = '0;
    free_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      slot_idx[w]  = SLOT_W'(int'(d_bucket_q) * WAYS + w);
      way_vld[w]   = slot_valid_q[slot_idx[w]];
      way_match[w] = way_vld[w] && (row_cur[w][VALUE_W-1:0] == d_q.value);
      if (way_match[w]) begin
        found     = 1'b1;
        match_way = WAY_W'(w);
      end
      if (!way_vld[w]) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    match_cnt = row_cur[match_way][ENTRY_W-1:VALUE_W];
  end

  // request decode and row update
  always_comb begin
    row_new     = row_cur;
    wr_en_d     = 1'b0;
    set_valid   = 1'b0;
    set_idx     = slot_idx[free_way];
    clear_all   = 1'b0;
    hit_d       = 1'b0;
    out_value_d = '0;
    status_d    = ST_OK;
    case (d_q.req)
      REQ_INSERT: begin
        if (found) begin
          if (match_cnt == COUNT_MAX) begin
            status_d = ST_SAT;
          end else begin
            row_new[match_way][ENTRY_W-1:VALUE_W] = match_cnt + COUNT_BITS'(1);
            wr_en_d = 1'b1;
          end
        end else if (has_free) begin
          row_new[free_way] = {COUNT_BITS'(1), d_q.value};
          wr_en_d   = 1'b1;
          set_valid = 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      REQ_PROBE: begin
        if (found && (match_cnt != '0)) begin
          row_new[match_way][ENTRY_W-1:VALUE_W] = match_cnt - COUNT_BITS'(1);
          wr_en_d     = 1'b1;
          hit_d       = 1'b1;
          out_value_d = d_q.value;
        end
      end
      REQ_CLEAR: begin
        clear_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // pipeline valids, slot valid bits and forwarding control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q     <= 1'b0;
      b_valid_q     <= 1'b0;
      c_valid_q     <= 1'b0;
      d_valid_q     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      wr_en_q       <= 1'b0;
      slot_valid_q  <= '0;
    end else if (en) begin
      a_valid_q     <= s_axis_tvalid;
      b_valid_q     <= a_valid_q;
      c_valid_q     <= b_valid_q;
      d_valid_q     <= c_valid_q;
      m_axis_tvalid <= d_valid_q;
      wr_en_q       <= d_valid_q && wr_en_d;
      if (d_valid_q && clear_all) begin
        slot_valid_q <= '0;
      end else if (d_valid_q && set_valid) begin
        slot_valid_q[set_idx] <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s_fire) begin
        a_q.req   <= req_e'(s_axis_tuser[REQ_W-1:0]);
        a_q.value <= s_axis_tdata;
        a_mag_q   <= in_mag;
      end
      b_q         <= a_q;
      b_mag_q     <= a_mag_q;
      prod_q      <= prod_d;
      c_q         <= b_q;
      rem_q       <= rem_d;
      d_q         <= c_q;
      d_bucket_q  <= bucket_c;
      wr_bucket_q <= d_bucket_q;
      wr_row_q    <= row_new;
      m_axis_tdata <= out_value_d;
      m_axis_tuser <= {5'd0, status_d, hit_d};
    end
  end

  // bucket row memory, read before write
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (d_valid_q && wr_en_d) begin
        slot_mem[d_bucket_q] <= row_new;
      end
      rd_q <= slot_mem[bucket_c];
    end
  end

  // checks
  a_hit_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == ST_OK))
    else $error("hit reported with nonzero status");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero value on a result without hit");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && d_valid_q && (d_q.req == REQ_CLEAR)) |=> (slot_valid_q == '0))
    else $error("clear left valid slots");

  a_bucket_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> (rem_fix < (BKT_W+1)'(BUCKETS)))
    else $error("bucket index out of range");

  a_stall_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(slot_valid_q))
    else $error("slot table changed during a stall");

endmodule
